/* src/mbe_pkg.sv */
package mbe_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned STEP_W = 31;
    localparam int unsigned COUNT_W = 13;
    localparam int unsigned PIXEL_W = 11;
    localparam int unsigned PROD_W = 2 * COORD_W;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned Q_FRAC = 28;

    // escape when re^2 + im^2 reaches 4.0 in Q8.56, i.e. 2^58
    localparam int unsigned ESCAPE_BIT = 2 * Q_FRAC + 2;

    localparam logic signed [COORD_W-1:0] RESET_X_MIN = -32'sd536870912;
    localparam logic signed [COORD_W-1:0] RESET_Y_MAX = 32'sd268435456;
    localparam logic [STEP_W-1:0] RESET_STEP_X = 31'd402653;
    localparam logic [STEP_W-1:0] RESET_STEP_Y = 31'd402653;
    localparam logic [COUNT_W-1:0] RESET_LIMIT = 13'd500;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_X_MIN  = 3'd0,
        CFG_Y_MAX  = 3'd1,
        CFG_STEP_X = 3'd2,
        CFG_STEP_Y = 3'd3,
        CFG_LIMIT  = 3'd4
    } t_cfg_index;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MCX  = 9'b000000010,
        S_MCY  = 9'b000000100,
        S_CIM  = 9'b000001000,
        S_TEST = 9'b000010000,
        S_M1   = 9'b000100000,
        S_M2   = 9'b001000000,
        S_M3   = 9'b010000000,
        S_M4   = 9'b100000000
    } t_state;

    // clamp a wide signed value into the signed 32-bit range
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = {{(PROD_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
        lo = {{(PROD_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
        if (x > hi) begin
            sat32 = {1'b0, {(COORD_W-1){1'b1}}};
        end else if (x < lo) begin
            sat32 = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            sat32 = x[COORD_W-1:0];
        end
    endfunction

endpackage

/* src/mandelbrot_escape_time_unit.sv */
// mandelbrot escape-time unit: one pixel at a time
// command channel: drive i_pixel_column, i_pixel_row with start high; the
// transfer happens on a clock edge where start is high and busy is low.
// busy stays high until the result has been issued.
// result channel: o_result_valid is high for exactly one cycle with
// o_escape_count; the receiver cannot stall and must take it then.
// config channel: i_cfg_valid with i_cfg_index and i_cfg_data, o_cfg_ready is
// always high; index 0 x min, 1 y max, 2 step x, 3 step y, 4 iteration limit.
// write registers only while busy is low and no result is pending.
// datapath: a single shared 32x32 signed multiplier does every product.
// mapping the pixel runs through MCX, MCY and CIM; each iteration runs M1, M2,
// M3 and M4 and then TEST (three products plus update and escape test), and
// the final TEST sets the registered strobe. busy drops with the strobe, so a
// new pixel can be taken at the edge that ends the strobe cycle, not before.
// reset (synchronous, active low) returns the config registers to their defaults
// and drops busy and the result strobe.
module mandelbrot_escape_time_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [mbe_pkg::PIXEL_W-1:0]          i_pixel_column,
    input  logic [mbe_pkg::PIXEL_W-1:0]          i_pixel_row,
    output logic                                 o_result_valid,
    output logic [mbe_pkg::COUNT_W-1:0]          o_escape_count,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mbe_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [mbe_pkg::COORD_W-1:0]          i_cfg_data
);
    import mbe_pkg::*;

    t_state r_state, n_state;

    logic signed [COORD_W-1:0] r_x_min, r_y_max;
    logic [STEP_W-1:0]         r_step_x, r_step_y;
    logic [COUNT_W-1:0]        r_limit;

    logic [PIXEL_W-1:0]        r_row;
    logic [PIXEL_W-1:0]        r_col;
    logic signed [COORD_W-1:0] r_cre, r_cim, r_re, r_im;
    logic signed [PROD_W-1:0]  r_prod, r_re2, r_diff;
    logic [COUNT_W-1:0]        r_k;
    logic                      r_result_valid;
    logic [COUNT_W-1:0]        r_escape_count;

    logic signed [COORD_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [PROD_W-1:0]         mag;
    logic                      stop;
    logic signed [PROD_W-1:0]  cre_sum, cim_sum, nre_sum, nim_sum;

    assign o_cfg_ready = 1'b1;
    assign busy = (r_state != S_IDLE);
    assign o_result_valid = r_result_valid;
    assign o_escape_count = r_escape_count;

    // shared multiplier operand select
    always_comb begin
        mul_a = r_re;
        mul_b = r_im;
        case (r_state)
            S_MCX: begin
                mul_a = signed'({{(COORD_W-PIXEL_W){1'b0}}, r_col});
                mul_b = signed'({1'b0, r_step_x});
            end
            S_MCY: begin
                mul_a = signed'({{(COORD_W-PIXEL_W){1'b0}}, r_row});
                mul_b = signed'({1'b0, r_step_y});
            end
            S_M2: begin
                mul_a = r_re;
                mul_b = r_re;
            end
            S_M3: begin
                mul_a = r_im;
                mul_b = r_im;
            end
            default: begin
                mul_a = r_re;
                mul_b = r_im;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign cre_sum = signed'({{(PROD_W-COORD_W){r_x_min[COORD_W-1]}}, r_x_min}) + r_prod;
    assign cim_sum = signed'({{(PROD_W-COORD_W){r_y_max[COORD_W-1]}}, r_y_max}) - r_prod;
    // arithmetic shift gives the floor of the scaled value
    assign nre_sum = (r_diff >>> Q_FRAC)
                   + signed'({{(PROD_W-COORD_W){r_cre[COORD_W-1]}}, r_cre});
    assign nim_sum = (r_prod >>> (Q_FRAC - 1))
                   + signed'({{(PROD_W-COORD_W){r_cim[COORD_W-1]}}, r_cim});

    // squares are nonnegative, so the sum is taken unsigned; re2 - diff = im2
    assign mag = unsigned'(r_re2) + unsigned'(r_re2 - r_diff);
    assign stop = (r_k >= r_limit) || (mag[PROD_W-1:ESCAPE_BIT] != '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (start) n_state = S_MCX;
            S_MCX:  n_state = S_MCY;
            S_MCY:  n_state = S_CIM;
            S_CIM:  n_state = S_TEST;
            S_TEST: n_state = stop ? S_IDLE : S_M1;
            S_M1:   n_state = S_M2;
            S_M2:   n_state = S_M3;
            S_M3:   n_state = S_M4;
            S_M4:   n_state = S_TEST;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_result_valid <= 1'b0;
            r_x_min <= RESET_X_MIN;
            r_y_max <= RESET_Y_MAX;
            r_step_x <= RESET_STEP_X;
            r_step_y <= RESET_STEP_Y;
            r_limit <= RESET_LIMIT;
        end else begin
            r_state <= n_state;
            r_result_valid <= (r_state == S_TEST) && stop;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_X_MIN:  r_x_min <= signed'(i_cfg_data);
                    CFG_Y_MAX:  r_y_max <= signed'(i_cfg_data);
                    CFG_STEP_X: r_step_x <= i_cfg_data[STEP_W-1:0];
                    CFG_STEP_Y: r_step_y <= i_cfg_data[STEP_W-1:0];
                    CFG_LIMIT:  r_limit <= i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            S_IDLE: begin
                r_col <= i_pixel_column;
                r_row <= i_pixel_row;
            end
            S_MCY: r_cre <= sat32(cre_sum);
            S_CIM: begin
                r_cim <= sat32(cim_sum);
                r_re <= '0;
                r_im <= '0;
                r_re2 <= '0;
                r_diff <= '0;
                r_k <= COUNT_W'(1);
            end
            S_TEST: if (stop) r_escape_count <= r_k;
            S_M1: begin
                r_re <= sat32(nre_sum);
                r_im <= sat32(nim_sum);
                r_k <= r_k + COUNT_W'(1);
            end
            S_M3: r_re2 <= r_prod;
            S_M4: r_diff <= r_re2 - r_prod;
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_escape_count != '0))
        else $error("escape count of zero issued");

    a_count_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_escape_count <= r_limit || o_escape_count == COUNT_W'(1)))
        else $error("escape count beyond iteration limit");

    a_start_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transfer did not make the unit busy");

    a_result_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while still busy");
`endif

endmodule
